[sv/dhd_pkg.sv]
// Shared constants, types and structs for the depth hole detector.
package dhd_pkg;

  localparam int unsigned WINDOW     = 10;
  localparam int unsigned CAL_WINDOW = 100;

  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned SUM_W      = 17;
  localparam int unsigned AVG_W      = 10;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned RUN_W      = 8;
  localparam int unsigned HITS_W     = 5;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam int unsigned LEN_MAX   = (WINDOW > CAL_WINDOW) ? WINDOW : CAL_WINDOW;
  localparam int unsigned IDX_W     = $clog2(LEN_MAX + 1);
  // Reciprocal divide: floor(x/d) == (x * (floor(2^S/d)+1)) >> S for x < 2^SUM_W
  localparam int unsigned DIV_SHIFT = SUM_W + $clog2(LEN_MAX);
  localparam int unsigned MUL_W     = DIV_SHIFT + 1;
  localparam int unsigned PROD_W    = SUM_W + MUL_W;

  localparam logic [MUL_W-1:0] RECIP_WIN = MUL_W'((64'd1 << DIV_SHIFT) / WINDOW + 64'd1);
  localparam logic [MUL_W-1:0] RECIP_CAL = MUL_W'((64'd1 << DIV_SHIFT) / CAL_WINDOW + 64'd1);
  localparam logic [IDX_W-1:0] LAST_WIN  = IDX_W'(WINDOW - 1);
  localparam logic [IDX_W-1:0] LAST_CAL  = IDX_W'(CAL_WINDOW - 1);

  localparam logic [RUN_W-1:0]  RUN_MAX  = '1;
  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  localparam logic [AVG_W-1:0] BASELINE_RST = AVG_W'(160);
  localparam logic [THR_W-1:0] THRESH_RST   = THR_W'(10);
  localparam logic [THR_W-1:0] MARGIN_RST   = THR_W'(5);
  localparam logic [CNT_W-1:0] DETECT_RST   = CNT_W'(2);
  localparam logic [CNT_W-1:0] FILLCNT_RST  = CNT_W'(2);

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_MARGIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_COUNT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_COUNT      = 2'd3;

  // Phase codes as seen on the result
  localparam logic [PHASE_W-1:0] PHASE_CAL  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_DET  = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_FILL = 2'd2;

  typedef enum logic [2:0] {
    PH_CAL  = 3'b001,
    PH_DET  = 3'b010,
    PH_FILL = 3'b100
  } phase_e;

  typedef struct packed {
    logic [THR_W-1:0] depth_threshold;
    logic [THR_W-1:0] fill_margin;
    logic [CNT_W-1:0] detect_count;
    logic [CNT_W-1:0] fill_count;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic             done;
    logic             cal;
    logic [SUM_W-1:0] sum;
  } acc_t;

  typedef struct packed {
    logic             valid;
    logic             done;
    logic [AVG_W-1:0] avg;
  } div_t;

  typedef struct packed {
    logic               valid;
    logic               done;
    logic [AVG_W-1:0]   avg;
    logic [PHASE_W-1:0] phase;
    logic               hole;
    logic               shutter;
    logic               filled;
  } res_t;

endpackage

[sv/depth_hole_detector.sv]
// Top level of the depth hole detector: input skid, config registers, pipeline.
//
// Usage:
//  - Input channel: one range sample per transfer on distance_mm_i (in_valid_i /
//    in_stall_o). Output channel: one result per input transfer (out_valid_o /
//    out_stall_i) carrying window_done, window_average, phase and three pulses.
//  - Pipeline: accumulate -> reciprocal divide -> phase decision/result register.
//    Each stage is registered; one sample per cycle is sustained while the
//    result register is not held by out_stall_i.
//  - The whole pipeline advances whenever the result register is empty or
//    being taken. A one-entry skid buffer on the input makes in_stall_o a pure
//    register: while a stalled result is held, at most one more sample is taken.
//  - Reset: phase is calibrate, baseline 160, all counters zero, registers
//    depth_threshold 10, fill_margin 5, detect_count 2, fill_count 2. The first
//    100 samples form the baseline; then windows of 10 samples are judged.
//  - Config: write enable, index and data; write only while the block is idle.
module depth_hole_detector (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dhd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dhd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [dhd_pkg::SAMPLE_W-1:0]    distance_mm_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            window_done_o,
  output logic [dhd_pkg::AVG_W-1:0]       window_average_o,
  output logic [dhd_pkg::PHASE_W-1:0]     phase_o,
  output logic                            hole_detected_o,
  output logic                            open_shutter_o,
  output logic                            hole_filled_o
);

  dhd_pkg::cfg_t                   cfg_q, cfg_d;
  logic                            skid_valid_q, skid_valid_d;
  logic [dhd_pkg::SAMPLE_W-1:0]    skid_data_q, skid_data_d;
  logic                            accept;
  logic                            adv;
  logic                            feed_valid;
  logic [dhd_pkg::SAMPLE_W-1:0]    feed_data;
  dhd_pkg::acc_t                   acc;
  dhd_pkg::div_t                   div;
  dhd_pkg::res_t                   res;

  // Config register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        dhd_pkg::CFG_DEPTH_THRESHOLD: cfg_d.depth_threshold = cfg_data_i;
        dhd_pkg::CFG_FILL_MARGIN:     cfg_d.fill_margin     = cfg_data_i;
        dhd_pkg::CFG_DETECT_COUNT:    cfg_d.detect_count    = cfg_data_i[dhd_pkg::CNT_W-1:0];
        dhd_pkg::CFG_FILL_COUNT:      cfg_d.fill_count      = cfg_data_i[dhd_pkg::CNT_W-1:0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  // Pipeline advances when the result slot frees up
  assign adv    = !res.valid || !out_stall_i;
  assign accept = in_valid_i && !skid_valid_q;

  // Skid: park a transfer that arrives while the pipeline holds
  always_comb begin
    feed_valid   = skid_valid_q || accept;
    feed_data    = skid_valid_q ? skid_data_q : distance_mm_i;
    skid_valid_d = skid_valid_q ? !adv : (accept && !adv);
    skid_data_d  = (accept && !adv) ? distance_mm_i : skid_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_threshold <= dhd_pkg::THRESH_RST;
      cfg_q.fill_margin     <= dhd_pkg::MARGIN_RST;
      cfg_q.detect_count    <= dhd_pkg::DETECT_RST;
      cfg_q.fill_count      <= dhd_pkg::FILLCNT_RST;
      skid_valid_q          <= 1'b0;
    end else begin
      cfg_q        <= cfg_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    skid_data_q <= skid_data_d;
  end

  dhd_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (feed_valid),
    .sample_i (feed_data),
    .acc_o    (acc)
  );

  dhd_divide u_divide (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .acc_i  (acc),
    .div_o  (div)
  );

  dhd_decide u_decide (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .cfg_i  (cfg_q),
    .div_i  (div),
    .res_o  (res)
  );

  assign in_stall_o       = skid_valid_q;
  assign out_valid_o      = res.valid;
  assign window_done_o    = res.done;
  assign window_average_o = res.avg;
  assign phase_o          = res.phase;
  assign hole_detected_o  = res.hole;
  assign open_shutter_o   = res.shutter;
  assign hole_filled_o    = res.filled;

endmodule

[sv/dhd_accum.sv]
// Window accumulator: running sum and sample index, flags window completion.
module dhd_accum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [dhd_pkg::SAMPLE_W-1:0]  sample_i,
  output dhd_pkg::acc_t                 acc_o
);

  logic [dhd_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [dhd_pkg::SUM_W-1:0] sum_q, sum_d, sum_add;
  logic                      cal_q, cal_d;
  logic [dhd_pkg::IDX_W-1:0] last;
  logic                      done;
  dhd_pkg::acc_t             acc_q, acc_d;

  always_comb begin
    sum_add = sum_q + dhd_pkg::SUM_W'(sample_i);
    last    = cal_q ? dhd_pkg::LAST_CAL : dhd_pkg::LAST_WIN;
    done    = (idx_q == last);
    idx_d   = idx_q;
    sum_d   = sum_q;
    cal_d   = cal_q;
    if (en_i && valid_i) begin
      if (done) begin
        idx_d = '0;
        sum_d = '0;
        cal_d = 1'b0;   // calibration window runs once after reset
      end else begin
        idx_d = idx_q + 1'b1;
        sum_d = sum_add;
      end
    end
    acc_d       = acc_q;
    if (en_i) begin
      acc_d.valid = valid_i;
      acc_d.done  = valid_i && done;
      acc_d.cal   = cal_q;
      acc_d.sum   = sum_add;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      sum_q <= '0;
      cal_q <= 1'b1;
      acc_q <= '0;
    end else begin
      idx_q <= idx_d;
      sum_q <= sum_d;
      cal_q <= cal_d;
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

[sv/dhd_divide.sv]
// Window average: constant divide by reciprocal multiply, registered.
module dhd_divide (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  dhd_pkg::acc_t acc_i,
  output dhd_pkg::div_t div_o
);

  logic [dhd_pkg::MUL_W-1:0]  recip;
  logic [dhd_pkg::PROD_W-1:0] prod;
  dhd_pkg::div_t              div_q, div_d;

  always_comb begin
    recip = acc_i.cal ? dhd_pkg::RECIP_CAL : dhd_pkg::RECIP_WIN;
    prod  = dhd_pkg::PROD_W'(acc_i.sum) * dhd_pkg::PROD_W'(recip);
    div_d = div_q;
    if (en_i) begin
      div_d.valid = acc_i.valid;
      div_d.done  = acc_i.done;
      div_d.avg   = acc_i.done ? prod[dhd_pkg::DIV_SHIFT +: dhd_pkg::AVG_W] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= '0;
    end else begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

[sv/dhd_decide.sv]
// Phase control: baseline, deep-run and fill counters, result register.
module dhd_decide (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  dhd_pkg::cfg_t cfg_i,
  input  dhd_pkg::div_t div_i,
  output dhd_pkg::res_t res_o
);

  dhd_pkg::phase_e             phase_q, phase_d;
  logic [dhd_pkg::AVG_W-1:0]   base_q, base_d;
  logic [dhd_pkg::RUN_W-1:0]   run_q, run_d, run_inc;
  logic [dhd_pkg::HITS_W-1:0]  hits_q, hits_d, hits_inc;
  logic [dhd_pkg::AVG_W:0]     deep_lim;
  logic                        deep;
  logic signed [dhd_pkg::AVG_W+1:0] fill_lvl;
  logic                        fill_hit;
  logic                        hole, shutter, filled;
  dhd_pkg::res_t               res_q, res_d;

  always_comb begin
    deep_lim = {1'b0, base_q} + (dhd_pkg::AVG_W+1)'(cfg_i.depth_threshold);
    deep     = ({1'b0, div_i.avg} > deep_lim);
    run_inc  = (run_q == dhd_pkg::RUN_MAX) ? run_q : run_q + 1'b1;
    fill_lvl = $signed({2'b00, base_q})
             - $signed((dhd_pkg::AVG_W+2)'(cfg_i.fill_margin));
    fill_hit = ($signed({2'b00, div_i.avg}) < fill_lvl);
    hits_inc = (hits_q == dhd_pkg::HITS_MAX) ? hits_q : hits_q + 1'b1;

    phase_d = phase_q;
    base_d  = base_q;
    run_d   = run_q;
    hits_d  = hits_q;
    hole    = 1'b0;
    shutter = 1'b0;
    filled  = 1'b0;

    if (div_i.valid && div_i.done) begin
      case (phase_q)
        dhd_pkg::PH_DET: begin
          run_d = deep ? run_inc : '0;
          if (run_d == dhd_pkg::RUN_W'(cfg_i.detect_count)) begin
            hole    = 1'b1;
            shutter = 1'b1;
            hits_d  = '0;
            phase_d = dhd_pkg::PH_FILL;
          end
        end
        dhd_pkg::PH_FILL: begin
          hits_d = fill_hit ? hits_inc : hits_q;
          if (hits_d > dhd_pkg::HITS_W'(cfg_i.fill_count)) begin
            filled  = 1'b1;
            phase_d = dhd_pkg::PH_DET;
          end else begin
            shutter = 1'b1;
          end
        end
        default: begin
          base_d  = div_i.avg;
          phase_d = dhd_pkg::PH_DET;
        end
      endcase
    end

    res_d = res_q;
    if (en_i) begin
      res_d.valid   = div_i.valid;
      res_d.done    = div_i.done;
      res_d.avg     = div_i.avg;
      res_d.hole    = hole;
      res_d.shutter = shutter;
      res_d.filled  = filled;
      case (phase_d)
        dhd_pkg::PH_DET:  res_d.phase = dhd_pkg::PHASE_DET;
        dhd_pkg::PH_FILL: res_d.phase = dhd_pkg::PHASE_FILL;
        default:          res_d.phase = dhd_pkg::PHASE_CAL;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dhd_pkg::PH_CAL;
      base_q  <= dhd_pkg::BASELINE_RST;
      run_q   <= '0;
      hits_q  <= '0;
      res_q   <= '0;
    end else begin
      if (en_i) begin
        phase_q <= phase_d;
        base_q  <= base_d;
        run_q   <= run_d;
        hits_q  <= hits_d;
      end
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[sv/dhd_checker.sv]
// Port-level checker for the depth hole detector, bound to the top level.
module dhd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            window_done_o,
  input logic [dhd_pkg::AVG_W-1:0]       window_average_o,
  input logic [dhd_pkg::PHASE_W-1:0]     phase_o,
  input logic                            hole_detected_o,
  input logic                            open_shutter_o,
  input logic                            hole_filled_o
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(window_average_o)
      && $stable(phase_o) && $stable(window_done_o))
    else $error("stalled result changed");

  // Decisions only on completed windows
  a_no_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !window_done_o |->
      !hole_detected_o && !open_shutter_o && !hole_filled_o && window_average_o == '0)
    else $error("decision without completed window");

  // A hole enters fill and asks for the shutter
  a_hole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hole_detected_o |->
      open_shutter_o && !hole_filled_o && phase_o == dhd_pkg::PHASE_FILL)
    else $error("hole pulse without fill entry");

  // Fill end returns to detect with no shutter request
  a_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hole_filled_o |->
      !open_shutter_o && phase_o == dhd_pkg::PHASE_DET)
    else $error("fill end inconsistent");

  // Stall on input only while results back up
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

endmodule

bind depth_hole_detector dhd_checker u_dhd_checker (.*);

[dv/depth_hole_detector_tb.sv]
// Self-checking testbench for depth_hole_detector: calibration, detect and fill windows.
module depth_hole_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LATENCY = 3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_SAMPLE   = 1023;
  localparam int RAND_PHASES  = 8;
  localparam int WIN_PER_RAND = 10;
  localparam int LONG_RUN_WIN = 30;

  // One expected result per accepted sample
  typedef struct packed {
    logic                        done;
    logic [dhd_pkg::AVG_W-1:0]   avg;
    logic [dhd_pkg::PHASE_W-1:0] phase;
    logic                        hole;
    logic                        shutter;
    logic                        filled;
  } dhd_report_t;

  logic                           clk          = 1'b0;
  logic                           rst_n        = 1'b0;
  logic                           cfg_we       = 1'b0;
  logic [dhd_pkg::CFG_IDX_W-1:0]  cfg_idx      = '0;
  logic [dhd_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
  logic                           in_valid     = 1'b0;
  logic                           in_stall;
  logic [dhd_pkg::SAMPLE_W-1:0]   distance     = '0;
  logic                           out_valid;
  logic                           out_stall    = 1'b0;
  logic                           window_done;
  logic [dhd_pkg::AVG_W-1:0]      window_average;
  logic [dhd_pkg::PHASE_W-1:0]    phase;
  logic                           hole_detected;
  logic                           open_shutter;
  logic                           hole_filled;

  // Shadow copy of the block: registers and working state
  logic [dhd_pkg::THR_W-1:0]   depth_thr;
  logic [dhd_pkg::THR_W-1:0]   fill_mrg;
  logic [dhd_pkg::CNT_W-1:0]   detect_len;
  logic [dhd_pkg::CNT_W-1:0]   fill_need;
  logic [dhd_pkg::PHASE_W-1:0] cur_phase;
  logic [6:0]                  acc_idx;
  logic [dhd_pkg::SUM_W-1:0]   acc_sum;
  logic [dhd_pkg::AVG_W-1:0]   road_level;
  logic [dhd_pkg::RUN_W-1:0]   deep_run;
  logic [dhd_pkg::HITS_W-1:0]  fill_seen;

  dhd_report_t report_q[$];
  int          errors         = 0;
  int          cycles         = 0;
  bit          tx_idle_en     = 1'b1;
  bit          rx_idle_en     = 1'b1;
  int          rx_hold_cycles = 0;

  depth_hole_detector dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .distance_mm_i    (distance),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .window_done_o    (window_done),
    .window_average_o (window_average),
    .phase_o          (phase),
    .hole_detected_o  (hole_detected),
    .open_shutter_o   (open_shutter),
    .hole_filled_o    (hole_filled)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int clip(input int v);
    if (v < 0) return 0;
    if (v > MAX_SAMPLE) return MAX_SAMPLE;
    return v;
  endfunction

  // Advance the shadow state by one sample and return the result it causes.
  function automatic dhd_report_t judge_sample(input logic [dhd_pkg::SAMPLE_W-1:0] d);
    dhd_report_t r;
    int unsigned len;
    int          fill_edge;
    r = '0;
    len = (cur_phase == dhd_pkg::PHASE_DET || cur_phase == dhd_pkg::PHASE_FILL)
        ? dhd_pkg::WINDOW : dhd_pkg::CAL_WINDOW;
    acc_sum = acc_sum + dhd_pkg::SUM_W'(d);
    if (int'(acc_idx) + 1 >= len) begin
      r.done  = 1'b1;
      r.avg   = dhd_pkg::AVG_W'(acc_sum / len);
      acc_sum = '0;
      acc_idx = '0;
      if (cur_phase == dhd_pkg::PHASE_DET) begin
        if (int'(r.avg) > int'(road_level) + int'(depth_thr)) begin
          if (deep_run != dhd_pkg::RUN_MAX) deep_run = deep_run + 1'b1;
        end else begin
          deep_run = '0;
        end
        // plain equality: a zero detect length fires on a cleared run
        if (int'(deep_run) == int'(detect_len)) begin
          r.hole    = 1'b1;
          r.shutter = 1'b1;
          fill_seen = '0;
          cur_phase = dhd_pkg::PHASE_FILL;
        end
      end else if (cur_phase == dhd_pkg::PHASE_FILL) begin
        // signed level: a margin above the baseline never counts a window
        fill_edge = int'(road_level) - int'(fill_mrg);
        if (int'(r.avg) < fill_edge && fill_seen != dhd_pkg::HITS_MAX) begin
          fill_seen = fill_seen + 1'b1;
        end
        if (int'(fill_seen) > int'(fill_need)) begin
          r.filled  = 1'b1;
          cur_phase = dhd_pkg::PHASE_DET;
        end else begin
          r.shutter = 1'b1;
        end
      end else begin
        road_level = r.avg;
        cur_phase  = dhd_pkg::PHASE_DET;
      end
    end else begin
      acc_idx = acc_idx + 1'b1;
    end
    r.phase = cur_phase;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Result checker: each transfer on the output side against the oldest prediction
  always @(posedge clk) begin : result_check
    dhd_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (report_q.size() == 0) begin
        flag_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = report_q.pop_front();
        if (window_done !== want.done)
          flag_mismatch("window_done", int'(window_done), int'(want.done));
        if (window_average !== want.avg)
          flag_mismatch("window_average", int'(window_average), int'(want.avg));
        if (phase !== want.phase)
          flag_mismatch("phase", int'(phase), int'(want.phase));
        if (hole_detected !== want.hole)
          flag_mismatch("hole_detected", int'(hole_detected), int'(want.hole));
        if (open_shutter !== want.shutter)
          flag_mismatch("open_shutter", int'(open_shutter), int'(want.shutter));
        if (hole_filled !== want.filled)
          flag_mismatch("hole_filled", int'(hole_filled), int'(want.filled));
      end
    end
  end

  // Receiver: random stall before each result, or a long hold when one is requested
  initial begin : result_sink
    int gap;
    forever begin
      if (rx_hold_cycles > 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        gap = rx_idle_en ? $urandom_range(0, 9) : 0;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  // Offer one sample, wait for its transfer, then record what it should produce.
  task automatic send_sample(input int d);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    distance <= dhd_pkg::SAMPLE_W'(d);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    report_q.push_back(judge_sample(dhd_pkg::SAMPLE_W'(d)));
  endtask

  // One detect/fill window; spread at full scale gives uniformly random samples
  task automatic send_window(input int level, input int spread);
    int v;
    for (int i = 0; i < dhd_pkg::WINDOW; i++) begin
      if (spread >= MAX_SAMPLE) v = $urandom_range(0, MAX_SAMPLE);
      else if (spread > 0) v = clip(level + $urandom_range(0, 2 * spread) - spread);
      else v = level;
      send_sample(v);
    end
  endtask

  // Let every pending result come back, then the pipeline settle.
  task automatic drain;
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Register write; the 4-bit counts get random upper data bits to show masking
  task automatic set_reg(input logic [dhd_pkg::CFG_IDX_W-1:0] idx, input int val);
    logic [dhd_pkg::CFG_DATA_W-1:0] data;
    data = dhd_pkg::CFG_DATA_W'(val);
    if (idx == dhd_pkg::CFG_DETECT_COUNT || idx == dhd_pkg::CFG_FILL_COUNT)
      data = {4'($urandom), 4'(val)};
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
    case (idx)
      dhd_pkg::CFG_DEPTH_THRESHOLD: depth_thr  = data;
      dhd_pkg::CFG_FILL_MARGIN:     fill_mrg   = data;
      dhd_pkg::CFG_DETECT_COUNT:    detect_len = data[dhd_pkg::CNT_W-1:0];
      dhd_pkg::CFG_FILL_COUNT:      fill_need  = data[dhd_pkg::CNT_W-1:0];
      default: ;
    endcase
  endtask

  // Baseline of about 200 mm so that a full margin drives the fill level negative
  task automatic test_calibration;
    send_sample(0);
    send_sample(MAX_SAMPLE);
    send_sample(512);
    send_sample(341);
    for (int i = 4; i < dhd_pkg::CAL_WINDOW; i++) send_sample($urandom_range(150, 250));
  endtask

  // Reset register values: two deep windows make a hole, three filled ones close it
  task automatic test_hole_and_fill;
    send_window(0, 0);
    send_window(MAX_SAMPLE, 0);
    send_window(MAX_SAMPLE, 0);
    send_window(0, 0);
    send_window(0, 0);
    send_window(0, 0);
    send_window(int'(road_level) + int'(depth_thr), 0);
    send_window(int'(road_level) + int'(depth_thr) + 1, 0);
  endtask

  task automatic test_register_extremes;
    drain();
    set_reg(dhd_pkg::CFG_DEPTH_THRESHOLD, 0);
    set_reg(dhd_pkg::CFG_FILL_MARGIN, 0);
    set_reg(dhd_pkg::CFG_DETECT_COUNT, 1);
    set_reg(dhd_pkg::CFG_FILL_COUNT, 0);
    send_window(int'(road_level) + 1, 0);
    send_window(int'(road_level), 0);
    send_window(int'(road_level) - 1, 0);
    // zero detect length: a shallow window clears the run and still flags a hole
    drain();
    set_reg(dhd_pkg::CFG_DETECT_COUNT, 0);
    send_window(int'(road_level), 0);
    // full margin: fill level below zero, nothing counts as filled
    drain();
    set_reg(dhd_pkg::CFG_FILL_MARGIN, 255);
    set_reg(dhd_pkg::CFG_FILL_COUNT, 15);
    send_window(0, 0);
    send_window(0, 0);
    drain();
    set_reg(dhd_pkg::CFG_FILL_MARGIN, 0);
    set_reg(dhd_pkg::CFG_FILL_COUNT, 0);
    send_window(0, 0);
    drain();
    set_reg(dhd_pkg::CFG_DEPTH_THRESHOLD, 255);
    set_reg(dhd_pkg::CFG_DETECT_COUNT, 15);
    send_window(MAX_SAMPLE, 0);
    send_window(int'(road_level) + 255, 0);
  endtask

  // Long deep run with a zero detect length at full rate, then one shallow window
  task automatic test_long_deep_run;
    drain();
    set_reg(dhd_pkg::CFG_FILL_MARGIN, 0);
    set_reg(dhd_pkg::CFG_FILL_COUNT, 0);
    while (cur_phase == dhd_pkg::PHASE_FILL) send_window(0, 0);
    drain();
    set_reg(dhd_pkg::CFG_DEPTH_THRESHOLD, 255);
    set_reg(dhd_pkg::CFG_DETECT_COUNT, 0);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int w = 0; w < LONG_RUN_WIN; w++) send_window(MAX_SAMPLE, 0);
    send_window(0, 0);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Receiver holds off while samples keep coming, so the input side must stall
  task automatic test_backpressure;
    drain();
    set_reg(dhd_pkg::CFG_DETECT_COUNT, 2);
    tx_idle_en = 1'b0;
    rx_hold_cycles = 200;
    for (int i = 0; i < 60; i++) send_sample($urandom_range(0, MAX_SAMPLE));
    tx_idle_en = 1'b1;
  endtask

  task automatic send_random_window;
    int deep_edge;
    int fill_edge;
    int kind;
    int level;
    int spread;
    deep_edge = int'(road_level) + int'(depth_thr);
    fill_edge = int'(road_level) - int'(fill_mrg);
    // in fill, lean toward windows around the fill level so filling can finish
    if (cur_phase == dhd_pkg::PHASE_FILL && $urandom_range(0, 1) == 1)
      kind = $urandom_range(3, 5);
    else kind = $urandom_range(0, 7);
    spread = 0;
    case (kind)
      0: level = (deep_edge >= MAX_SAMPLE) ? MAX_SAMPLE
                                           : $urandom_range(deep_edge + 1, MAX_SAMPLE);
      1: level = clip(deep_edge);
      2: level = clip(deep_edge + 1);
      3: level = (fill_edge > 0) ? $urandom_range(0, fill_edge - 1)
                                 : $urandom_range(0, MAX_SAMPLE);
      4: level = clip(fill_edge);
      5: level = clip(fill_edge - 1);
      6: begin
        level  = 0;
        spread = MAX_SAMPLE;
      end
      default: begin
        level  = $urandom_range(0, MAX_SAMPLE);
        spread = $urandom_range(1, 3);
      end
    endcase
    send_window(level, spread);
  endtask

  task automatic test_random_windows;
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      case ($urandom_range(0, 3))
        0: set_reg(dhd_pkg::CFG_DEPTH_THRESHOLD, 0);
        1: set_reg(dhd_pkg::CFG_DEPTH_THRESHOLD, 255);
        default: set_reg(dhd_pkg::CFG_DEPTH_THRESHOLD, $urandom_range(0, 60));
      endcase
      case ($urandom_range(0, 3))
        0: set_reg(dhd_pkg::CFG_FILL_MARGIN, 0);
        1: set_reg(dhd_pkg::CFG_FILL_MARGIN, 255);
        default: set_reg(dhd_pkg::CFG_FILL_MARGIN, $urandom_range(0, 60));
      endcase
      set_reg(dhd_pkg::CFG_DETECT_COUNT,
              ($urandom_range(0, 4) == 0) ? 15 : $urandom_range(1, 4));
      case ($urandom_range(0, 4))
        0: set_reg(dhd_pkg::CFG_FILL_COUNT, 15);
        1: set_reg(dhd_pkg::CFG_FILL_COUNT, 0);
        default: set_reg(dhd_pkg::CFG_FILL_COUNT, $urandom_range(1, 4));
      endcase
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      for (int w = 0; w < WIN_PER_RAND; w++) send_random_window();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    depth_thr  = dhd_pkg::THRESH_RST;
    fill_mrg   = dhd_pkg::MARGIN_RST;
    detect_len = dhd_pkg::DETECT_RST;
    fill_need  = dhd_pkg::FILLCNT_RST;
    cur_phase  = dhd_pkg::PHASE_CAL;
    acc_idx    = '0;
    acc_sum    = '0;
    road_level = dhd_pkg::BASELINE_RST;
    deep_run   = '0;
    fill_seen  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_calibration();
    test_hole_and_fill();
    test_register_extremes();
    test_long_deep_run();
    test_backpressure();
    test_random_windows();
    drain();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
